>>> design/ordered_set_rank_engine_defines.svh
// Assertion macros for the rank engine design.
`ifndef ORDERED_SET_RANK_ENGINE_DEFINES_SVH
`define ORDERED_SET_RANK_ENGINE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define OSRE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property checked in every cycle, reset included.
`define OSRE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> design/osre_pkg.sv
`default_nettype none
package osre_pkg;

    localparam int unsigned Capacity = 256;
    localparam int unsigned KeyW = 32;
    localparam int unsigned CountW = 9;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_EXISTS = 3'd2,
        REQ_NEXT   = 3'd3,
        REQ_PREV   = 3'd4,
        REQ_KTH    = 3'd5,
        REQ_RSVD6  = 3'd6,
        REQ_RSVD7  = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] key;
        logic signed [31:0] rank;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_key;
        logic [8:0]         entry_count;
    } t_out_item;

endpackage
`default_nettype wire

>>> design/osre_keymem.sv
`default_nettype none
// Sorted key store: one synchronous read port and one write port.
module osre_keymem #(
    parameter int unsigned CAPACITY = osre_pkg::Capacity,
    parameter int unsigned AW = $clog2(CAPACITY)
) (
    input  wire logic                 i_clk,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic signed [31:0]        o_rd_data,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic signed [31:0]   i_wr_data
);
    logic signed [31:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

>>> design/ordered_set_rank_engine.sv
`default_nettype none
// Channel  | Direction | Payload              | Handshake
// input    | in        | osre_pkg::t_in_item  | i_in_valid / o_in_stall
// output   | out       | osre_pkg::t_out_item | o_out_valid / i_out_stall
//
// One item at a time: accept, then a binary search over the c held keys,
// then the steps end, fetch, data and result.
// Kth skips the search; codes six and seven go straight to the result.
// Insert then shifts the tail up from position p, delete shifts it down.
// Reset is synchronous; the store is empty after it and needs no clearing.
// A stalled result holds in the output register; the next item is taken but waits.
module ordered_set_rank_engine #(
    parameter int unsigned CAPACITY = osre_pkg::Capacity
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire osre_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output osre_pkg::t_out_item      o_out_data
);
`include "ordered_set_rank_engine_defines.svh"

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SADDR, S_SCMP, S_FETCH, S_FDATA, S_SHRD, S_SHWR, S_DONE
    } t_state;

    t_state                 r_state;
    osre_pkg::t_req         r_req;
    logic signed [31:0]     r_key;
    logic signed [31:0]     r_rank;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_lo;
    logic [CW-1:0]          r_hi;
    logic [CW-1:0]          r_idx;
    logic [1:0]             r_status;
    logic signed [31:0]     r_res;
    logic signed [31:0]     r_carry;
    logic                   r_out_valid;
    osre_pkg::t_out_item    r_out;

    logic [CW-1:0]          mid;
    logic [AW-1:0]          rd_addr;
    logic signed [31:0]     rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic signed [31:0]     wr_data;
    logic                   go_right;
    logic                   found;
    logic [CW:0]            mid_sum;
    logic [CW-1:0]          idx_m1;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign idx_m1  = r_idx - 1'b1;
    assign go_right = (r_req == osre_pkg::REQ_NEXT) ? (rd_data <= r_key)
                                                     : (rd_data < r_key);

    osre_keymem #(.CAPACITY(CAPACITY), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_SADDR) begin
            rd_addr = mid[AW-1:0];
        end
        wr_en   = (r_state == S_SHWR);
        wr_addr = r_idx[AW-1:0];
        wr_data = r_carry;
        // Delete moves the entry just read down by one place.
        if (r_req == osre_pkg::REQ_DELETE) begin
            wr_addr = idx_m1[AW-1:0];
            wr_data = rd_data;
        end
    end

    assign found = (r_lo < r_count) && (rd_data == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= osre_pkg::t_req'(i_in_data.req_type);
                        r_key    <= i_in_data.key;
                        r_rank   <= i_in_data.rank;
                        r_lo     <= '0;
                        r_hi     <= r_count;
                        r_status <= osre_pkg::ST_NONE;
                        r_res    <= '0;
                        if (i_in_data.req_type == osre_pkg::REQ_KTH) begin
                            r_state <= S_SCMP;
                        end else if (i_in_data.req_type == osre_pkg::REQ_RSVD6
                                  || i_in_data.req_type == osre_pkg::REQ_RSVD7) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SADDR;
                        end
                    end
                end
                S_SADDR: begin
                    if (r_lo < r_hi) begin
                        r_state <= S_SCMP;
                    end else begin
                        // Prev reads the entry just below the search position.
                        if (r_req == osre_pkg::REQ_PREV) begin
                            r_idx <= r_lo - 1'b1;
                        end else begin
                            r_idx <= r_lo;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_SCMP: begin
                    if (r_req == osre_pkg::REQ_KTH) begin
                        // Rank check: non-negative and below the count.
                        if (!r_rank[31] && r_rank[30:0] < 31'(r_count)) begin
                            r_idx   <= r_rank[CW-1:0];
                            r_state <= S_FETCH;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        if (go_right) begin
                            r_lo <= mid + 1'b1;
                        end else begin
                            r_hi <= mid;
                        end
                        r_state <= S_SADDR;
                    end
                end
                S_FETCH: begin
                    r_state <= S_FDATA;
                end
                S_FDATA: begin
                    r_state <= S_DONE;
                    unique case (r_req) inside
                        osre_pkg::REQ_INSERT: begin
                            if (found) begin
                                r_status <= osre_pkg::ST_OK;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                r_status <= osre_pkg::ST_FULL;
                            end else begin
                                r_status <= osre_pkg::ST_OK;
                                r_carry  <= r_key;
                                r_idx    <= r_lo;
                                r_count  <= r_count + 1'b1;
                                r_state  <= S_SHRD;
                            end
                        end
                        osre_pkg::REQ_DELETE: begin
                            if (found) begin
                                r_status <= osre_pkg::ST_OK;
                                r_count  <= r_count - 1'b1;
                                r_idx    <= r_lo + 1'b1;
                                r_state  <= S_SHRD;
                            end
                        end
                        osre_pkg::REQ_EXISTS: begin
                            if (found) begin
                                r_status <= osre_pkg::ST_OK;
                            end
                        end
                        osre_pkg::REQ_NEXT, osre_pkg::REQ_KTH: begin
                            if (r_req == osre_pkg::REQ_KTH || r_lo < r_count) begin
                                r_status <= osre_pkg::ST_OK;
                                r_res    <= rd_data;
                            end
                        end
                        osre_pkg::REQ_PREV: begin
                            if (r_lo != '0) begin
                                r_status <= osre_pkg::ST_OK;
                                r_res    <= rd_data;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_SHRD: begin
                    // Insert: read old entry then write the carried key.
                    // Delete: read entry idx, write it to idx-1.
                    if (r_req == osre_pkg::REQ_INSERT) begin
                        r_state <= (r_idx < r_count) ? S_SHWR : S_DONE;
                    end else begin
                        r_state <= (r_idx <= r_count) ? S_SHWR : S_DONE;
                    end
                end
                S_SHWR: begin
                    if (r_req == osre_pkg::REQ_INSERT) begin
                        r_carry <= rd_data;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SHRD;
                    end else begin
                        r_carry <= rd_data;
                        r_state <= S_SHRD;
                        r_idx   <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid           <= 1'b1;
                        r_out.status          <= r_status;
                        r_out.result_key      <= r_res;
                        r_out.entry_count     <= 9'(r_count);
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `OSRE_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "key count above capacity")
    `OSRE_ASSERT(a_done_out, (r_state == S_DONE && !r_out_valid) |=> r_out_valid,
                 "finished item not presented")
    `OSRE_ASSERT(a_wr_in_range, wr_en |-> (r_idx < CW'(CAPACITY)), "shift write out of range")
endmodule
`default_nettype wire

>>> tb/sv/ordered_set_rank_engine_test.sv
`timescale 1ns / 1ps
module ordered_set_rank_engine_test;

    localparam int unsigned CycleLimit = 3000000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    osre_pkg::t_in_item     i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    osre_pkg::t_out_item    o_out_data;

    ordered_set_rank_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Shadow copy of the set, held sorted in ascending order.
    logic signed [31:0]     held_keys[$];
    osre_pkg::t_out_item    pending_answers[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_req = 0;
    int unsigned hold_off_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Works out the answer for one request and updates the shadow set.
    function automatic osre_pkg::t_out_item answer_request(osre_pkg::t_in_item req);
        osre_pkg::t_out_item ans;
        int        pos;
        bit        present;
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < req.key) pos++;
        present = (pos < held_keys.size()) && (held_keys[pos] == req.key);
        ans.status = osre_pkg::ST_NONE;
        ans.result_key = '0;
        case (osre_pkg::t_req'(req.req_type))
            osre_pkg::REQ_INSERT: begin
                if (present) begin
                    ans.status = osre_pkg::ST_OK;
                end else if (held_keys.size() >= osre_pkg::Capacity) begin
                    ans.status = osre_pkg::ST_FULL;
                end else begin
                    held_keys.insert(pos, req.key);
                    ans.status = osre_pkg::ST_OK;
                end
            end
            osre_pkg::REQ_DELETE: begin
                if (present) begin
                    held_keys.delete(pos);
                    ans.status = osre_pkg::ST_OK;
                end
            end
            osre_pkg::REQ_EXISTS: begin
                if (present) ans.status = osre_pkg::ST_OK;
            end
            osre_pkg::REQ_NEXT: begin
                if (present) pos++;
                if (pos < held_keys.size()) begin
                    ans.status = osre_pkg::ST_OK;
                    ans.result_key = held_keys[pos];
                end
            end
            osre_pkg::REQ_PREV: begin
                if (pos > 0) begin
                    ans.status = osre_pkg::ST_OK;
                    ans.result_key = held_keys[pos-1];
                end
            end
            osre_pkg::REQ_KTH: begin
                if (req.rank >= 0 && req.rank < held_keys.size()) begin
                    ans.status = osre_pkg::ST_OK;
                    ans.result_key = held_keys[req.rank];
                end
            end
            default: ;
        endcase
        ans.entry_count = 9'(held_keys.size());
        return ans;
    endfunction

    task automatic send_request(input osre_pkg::t_req op, input logic signed [31:0] key,
                                input logic signed [31:0] rank);
        osre_pkg::t_in_item req;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        req.req_type = op;
        req.key = key;
        req.rank = rank;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_answers.insert(pending_answers.size(), answer_request(req));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    function automatic logic signed [31:0] pick_key();
        logic signed [31:0] k;
        case ($urandom_range(3))
            0: k = $urandom();
            1: k = held_keys.size() != 0 ? held_keys[$urandom_range(held_keys.size()-1)]
                                         : 32'sd0;
            default: k = $signed($urandom_range(60)) - 32'sd30;
        endcase
        return k;
    endfunction

    task automatic test_directed();
        send_request(osre_pkg::REQ_PREV, 32'sd0, 32'sd0);
        send_request(osre_pkg::REQ_NEXT, 32'sd0, 32'sd0);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sd0);
        send_request(osre_pkg::REQ_DELETE, 32'sd5, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, 32'sh7fff_ffff, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, 32'sd0, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, 32'sd0, 32'sd0);
        send_request(osre_pkg::REQ_EXISTS, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_EXISTS, 32'sd7, 32'sd0);
        send_request(osre_pkg::REQ_NEXT, 32'sh7fff_ffff, 32'sd0);
        send_request(osre_pkg::REQ_NEXT, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_PREV, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_PREV, 32'sh7fff_ffff, 32'sd0);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sd2);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sd3);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sh8000_0000);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sh7fff_ffff);
        send_request(osre_pkg::REQ_KTH, 32'sd0, -32'sd1);
        send_request(osre_pkg::REQ_RSVD6, 32'shffff_ffff, 32'shffff_ffff);
        send_request(osre_pkg::REQ_RSVD7, 32'sd1, 32'sd1);
        send_request(osre_pkg::REQ_DELETE, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_DELETE, 32'sh8000_0000, 32'sd0);
        send_request(osre_pkg::REQ_KTH, 32'sd0, 32'sd0);
    endtask

    // Fills the table to capacity, so refusals and full-table inserts of present keys occur.
    task automatic test_full_table();
        int i;
        for (i = 0; i < osre_pkg::Capacity + 4; i++)
            send_request(osre_pkg::REQ_INSERT, $signed(i * 3) - 32'sd380, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, 32'sd1000001, 32'sd0);
        send_request(osre_pkg::REQ_INSERT, -32'sd380, 32'sd0);
        send_request(osre_pkg::REQ_KTH, 32'sd0, $signed(osre_pkg::Capacity - 1));
        send_request(osre_pkg::REQ_KTH, 32'sd0, $signed(osre_pkg::Capacity));
        for (i = 0; i < osre_pkg::Capacity - 40; i++)
            send_request(osre_pkg::REQ_DELETE, held_keys[$urandom_range(held_keys.size()-1)],
                         32'sd0);
    endtask

    task automatic test_random(input int unsigned count);
        int     i;
        osre_pkg::t_req   op;
        logic signed [31:0] rank;
        for (i = 0; i < count; i++) begin
            op = osre_pkg::t_req'(3'($urandom_range(20) == 0 ? $urandom_range(7)
                                                             : $urandom_range(5)));
            if (held_keys.size() < 12 && $urandom_range(1))
                op = osre_pkg::REQ_INSERT;
            if ($urandom_range(7) == 0) rank = $urandom();
            else rank = $signed($urandom_range(held_keys.size() + 2)) - 32'sd1;
            send_request(op, pick_key(), rank);
        end
    endtask

    // The receiver holds off for a long stretch while items keep arriving.
    task automatic test_back_pressure();
        hold_off_req = hold_off_req + 400;
        test_random(40);
        wait_drained();
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", o_out_data);
            end else begin
                if (o_out_data.status !== pending_answers[0].status ||
                    o_out_data.result_key !== pending_answers[0].result_key ||
                    o_out_data.entry_count !== pending_answers[0].entry_count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("expected %p got %p", pending_answers[0], o_out_data);
                end
                void'(pending_answers.pop_front());
            end
        end
    end

    // Receiver stall driver; a requested hold-off is counted out here.
    always @(posedge i_clk) begin
        if (hold_off_seen < hold_off_req) begin
            hold_off_seen <= hold_off_seen + 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int n;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 25;
        recv_idle_pct = 82;
        test_directed();
        wait_drained();
        test_back_pressure();
        test_full_table();
        wait_drained();
        test_random(250);
        send_idle_pct = 82;
        recv_idle_pct = 25;
        test_random(250);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);

        i_in_valid <= 1'b0;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending_answers.size() != 0 && n < 100000);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/osre_pkg.sv
design/osre_keymem.sv
design/ordered_set_rank_engine.sv
tb/sv/ordered_set_rank_engine_test.sv
